[src/sem_pkg.sv]
// Shared constants, types and a helper function of the Sobel edge magnitude block.
`default_nettype none

package sem_pkg;

	localparam int unsigned PIX_W          = 8;
	localparam int unsigned CFG_W          = 11;
	localparam int unsigned POS_W          = 20;
	localparam int unsigned APB_DATA_W     = 32;
	localparam int unsigned APB_ADDR_W     = 3;
	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 1024;
	localparam int unsigned DIM_MIN        = 3;
	localparam logic [CFG_W-1:0] DIM_RESET = 11'd10;
	localparam logic [PIX_W-1:0] MAG_MAX   = 8'd255;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input int unsigned hi);
		logic [CFG_W-1:0] r;
		r = v;
		if (32'(v) < DIM_MIN) begin
			r = CFG_W'(DIM_MIN);
		end else if (32'(v) > hi) begin
			r = CFG_W'(hi);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[src/sem_line_buffer.sv]
// Two-line pixel store in one synchronous memory with write-to-read forwarding.
`default_nettype none

module sem_line_buffer #(
	parameter int unsigned DEPTH = sem_pkg::DEF_MAX_WIDTH,
	parameter int unsigned AW    = $clog2(DEPTH),
	parameter int unsigned DW    = 2 * sem_pkg::PIX_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_q;
	logic [DW-1:0] fwd_data_q;
	logic          fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// A read that meets a write to the same entry takes the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

`default_nettype wire

[src/sobel_edge_magnitude.sv]
// Top level of the 3x3 Sobel edge magnitude block over a raster pixel stream.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid, in_stall    pixel
// out      output     out_valid, out_stall  magnitude, position, frame_last
// cfg      input      APB write/read        image_width, image_height
//
// One pixel is accepted per cycle unless stalled; each result leaves from a register.
// The rate is set by the single line memory, read and written once per pixel.
// Reset clears counters, window and handshake state; line memory is not cleared.
// A stalled output holds in its register while a skid stage takes one more
// result; only a full skid stage stalls the input.
`default_nettype none

module sobel_edge_magnitude #(
	parameter int unsigned MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [sem_pkg::PIX_W-1:0]         pixel,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [sem_pkg::PIX_W-1:0]         magnitude,
	output logic      [sem_pkg::POS_W-1:0]         position,
	output logic                                   frame_last,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [sem_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [sem_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [sem_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready
);

	localparam int unsigned PW     = sem_pkg::PIX_W;
	localparam int unsigned CW     = sem_pkg::CFG_W;
	localparam int unsigned POS_W  = sem_pkg::POS_W;
	localparam int unsigned AW     = $clog2(MAX_WIDTH);
	localparam int unsigned CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int unsigned WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int unsigned PROD_W = 2 * CW;
	localparam int unsigned SUM_W  = PW + 4;

	localparam logic [CW-1:0] RST_W = sem_pkg::clamp_dim(sem_pkg::DIM_RESET, MAX_WIDTH);
	localparam logic [CW-1:0] RST_H = sem_pkg::clamp_dim(sem_pkg::DIM_RESET, MAX_HEIGHT);

	// Configuration registers and derived frame constants.
	logic [CW-1:0]     image_width_q;
	logic [CW-1:0]     image_height_q;
	logic [CW-1:0]     wc;
	logic [CW-1:0]     hc;
	logic [PROD_W-1:0] prod;
	logic [CW+1:0]     two_w;
	logic [CW-1:0]     w_m1_q;
	logic [CNT_W-1:0]  warm_q;
	logic [CNT_W-1:0]  off_q;
	logic [CNT_W-1:0]  total_m1_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= sem_pkg::DIM_RESET;
			image_height_q <= sem_pkg::DIM_RESET;
		end else if (cfg_wr) begin
			case (sem_pkg::reg_idx_t'(paddr[2]))
				sem_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[CW-1:0];
				end
				sem_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= pwdata[CW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (sem_pkg::reg_idx_t'(paddr[2]))
			sem_pkg::REG_IMAGE_WIDTH:  prdata = sem_pkg::APB_DATA_W'(image_width_q);
			sem_pkg::REG_IMAGE_HEIGHT: prdata = sem_pkg::APB_DATA_W'(image_height_q);
			default:                   prdata = '0;
		endcase
	end

	assign wc    = sem_pkg::clamp_dim(image_width_q, MAX_WIDTH);
	assign hc    = sem_pkg::clamp_dim(image_height_q, MAX_HEIGHT);
	assign prod  = PROD_W'(wc) * PROD_W'(hc);
	assign two_w = {1'b0, wc, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_m1_q     <= RST_W - CW'(1);
			warm_q     <= CNT_W'({1'b0, RST_W, 1'b0} + (CW + 2)'(2));
			off_q      <= CNT_W'({1'b0, RST_W, 1'b0} + (CW + 2)'(1));
			total_m1_q <= CNT_W'(PROD_W'(RST_W) * PROD_W'(RST_H) - PROD_W'(1));
		end else begin
			w_m1_q     <= wc - CW'(1);
			warm_q     <= CNT_W'(two_w + (CW + 2)'(2));
			off_q      <= CNT_W'(two_w + (CW + 2)'(1));
			total_m1_q <= CNT_W'(prod - PROD_W'(1));
		end
	end

	// Pipeline control: everything advances unless the skid stage is full.
	logic skid_valid_q;
	logic en;
	logic accept;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;

	// Stage 0: counters, memory read issue.
	logic [CNT_W-1:0]  cnt_q;
	logic [AW-1:0]     col_q;
	logic              last0;
	logic              emit0;
	logic [WIDE_W-1:0] pos_wide;

	assign last0    = cnt_q >= total_m1_q;
	assign emit0    = cnt_q >= warm_q;
	assign pos_wide = WIDE_W'(cnt_q) - WIDE_W'(off_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last0) begin
				cnt_q <= '0;
				col_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (32'(col_q) >= 32'(w_m1_q)) begin
					col_q <= '0;
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// Stage 1: line memory data arrives and is written back.
	logic              valid_s1;
	logic [PW-1:0]     px_s1;
	logic [AW-1:0]     addr_s1;
	logic              emit_s1;
	logic              last_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [2*PW-1:0]   lb_rd;
	logic [PW-1:0]     mid_s1;
	logic [PW-1:0]     top_s1;
	logic              lb_wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= pixel;
			addr_s1 <= col_q;
			emit_s1 <= emit0;
			last_s1 <= last0;
			pos_s1  <= pos_wide[POS_W-1:0];
		end
	end

	assign mid_s1   = lb_rd[PW-1:0];
	assign top_s1   = lb_rd[2*PW-1:PW];
	assign lb_wr_en = en && valid_s1;

	sem_line_buffer #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW),
		.DW    (2 * PW)
	) u_line_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (lb_rd),
		.wr_en   (lb_wr_en),
		.wr_addr (addr_s1),
		.wr_data ({mid_s1, px_s1})
	);

	// Stage 2: window shift and Sobel sums.
	logic [PW-1:0]    win_q [3][3];
	logic             valid_s2;
	logic             emit_s2;
	logic             last_s2;
	logic [POS_W-1:0] pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= top_s1;
				win_q[1][2] <= mid_s1;
				win_q[2][2] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			pos_s2  <= pos_s1;
		end
	end

	logic signed [SUM_W-1:0] hs;
	logic signed [SUM_W-1:0] vs;
	logic        [SUM_W-1:0] hs_abs;
	logic        [SUM_W-1:0] vs_abs;
	logic        [SUM_W-1:0] mag_sum;
	logic        [PW-1:0]    mag;

	always_comb begin
		hs = SUM_W'(win_q[2][0]) + (SUM_W'(win_q[2][1]) <<< 1) + SUM_W'(win_q[2][2])
			- SUM_W'(win_q[0][0]) - (SUM_W'(win_q[0][1]) <<< 1) - SUM_W'(win_q[0][2]);
		vs = SUM_W'(win_q[0][2]) + (SUM_W'(win_q[1][2]) <<< 1) + SUM_W'(win_q[2][2])
			- SUM_W'(win_q[0][0]) - (SUM_W'(win_q[1][0]) <<< 1) - SUM_W'(win_q[2][0]);
		hs_abs  = hs[SUM_W-1] ? SUM_W'(-hs) : SUM_W'(hs);
		vs_abs  = vs[SUM_W-1] ? SUM_W'(-vs) : SUM_W'(vs);
		mag_sum = hs_abs + vs_abs;
		mag     = (mag_sum > SUM_W'(sem_pkg::MAG_MAX)) ? sem_pkg::MAG_MAX : mag_sum[PW-1:0];
	end

	// Output register with a one-entry skid stage.
	logic             push;
	logic             take;
	logic             out_valid_q;
	logic [PW-1:0]    out_mag_q;
	logic [POS_W-1:0] out_pos_q;
	logic             out_last_q;
	logic [PW-1:0]    skid_mag_q;
	logic [POS_W-1:0] skid_pos_q;
	logic             skid_last_q;

	assign push = en && valid_s2 && emit_s2;
	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_mag_q  <= skid_mag_q;
				out_pos_q  <= skid_pos_q;
				out_last_q <= skid_last_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_mag_q  <= mag;
				out_pos_q  <= pos_s2;
				out_last_q <= last_s2;
			end else begin
				skid_mag_q  <= mag;
				skid_pos_q  <= pos_s2;
				skid_last_q <= last_s2;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign magnitude  = out_mag_q;
	assign position   = out_pos_q;
	assign frame_last = out_last_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> !skid_valid_q)
		else $error("skid stage did not drain after an output transfer");

	a_stalled_push_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && out_stall) |=> skid_valid_q)
		else $error("result pushed into a stalled output was lost");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (32'(col_q) < MAX_WIDTH))
		else $error("line memory address beyond its depth");

endmodule

`default_nettype wire
